### sv/lpsd_pkg.sv
// lpsd_pkg: shared types, constants and helpers for the length-prefixed string decoder
// no dependencies; imported by every module of the block

package lpsd_pkg;

   localparam int BUF_SIZE_W  = 17;
   localparam int LEN_W       = 31;
   localparam int CODE_W      = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;
   localparam int ROOM_NEEDED = 4;

   localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 17'd256;
   localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_MAX   = 17'h10000;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic {
      PHASE_LEN,
      PHASE_CHARS
   } phase_type;

   typedef struct packed {
      kind_type            kind;
      logic [CODE_W-1:0]   code;
      logic [CODE_W-1:0]   index;
      logic [CODE_W-1:0]   length;
      logic                last;
   } item_type;

   typedef struct packed {
      logic [1:0] count;
      item_type   first;
      item_type   second;
   } push_type;

   // number of characters kept: buffer size clamped to 1..65536, minus one
   function automatic logic [CODE_W-1:0] keep_limit(input logic [BUF_SIZE_W-1:0] bs);
      logic [CODE_W-1:0] lim;
      if (bs == '0) begin
         lim = '0;
      end else if (bs >= BUF_SIZE_MAX) begin
         lim = '1;
      end else begin
         lim = bs[CODE_W-1:0] - 16'd1;
      end
      return lim;
   endfunction

endpackage

### sv/lpsd_decode.sv
// lpsd_decode: input beat register, varint length and character decode, string state
// depends on lpsd_pkg; hands up to two result items per beat to the result queue

module lpsd_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [7:0]                      in_byte,
   input  logic [lpsd_pkg::BUF_SIZE_W-1:0] buffer_size,
   output lpsd_pkg::push_type              push
);
   import lpsd_pkg::*;

   logic              beat_valid_ff, beat_valid_in;
   logic [7:0]        beat_byte_ff;
   phase_type         phase_ff, phase_in;
   logic [2:0]        vcount_ff, vcount_in;
   logic [LEN_W-1:0]  declared_ff, declared_in;
   logic [LEN_W-1:0]  chars_ff, chars_in;
   logic [1:0]        cont_ff, cont_in;
   logic [CODE_W-1:0] partial_ff, partial_in;

   logic [6:0]        payload;
   logic [CODE_W-1:0] keep;
   logic              len_err, len_more;
   logic [LEN_W-1:0]  len_add, len_new;
   logic              char_done;
   logic [CODE_W-1:0] char_code;
   logic [LEN_W-1:0]  chars_next;
   logic              kept, str_end;
   logic [CODE_W-1:0] end_len;

   assign beat_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
      end else begin
         beat_valid_ff <= beat_valid_in;
      end
      beat_byte_ff <= in_byte;
   end

   // shared decode of the registered beat
   always_comb begin
      payload  = beat_byte_ff[6:0];
      keep     = keep_limit(buffer_size);
      len_err  = (vcount_ff >= 3'd4) && ((payload[6:3] != 4'd0) || beat_byte_ff[7]);
      len_more = (vcount_ff < 3'd4) && beat_byte_ff[7];
      case (vcount_ff)
         3'd0:    len_add = {24'd0, payload};
         3'd1:    len_add = {17'd0, payload, 7'd0};
         3'd2:    len_add = {10'd0, payload, 14'd0};
         3'd3:    len_add = {3'd0, payload, 21'd0};
         default: len_add = {payload[2:0], 28'd0};
      endcase
      len_new = declared_ff | len_add;

      char_done = 1'b0;
      char_code = '0;
      if (cont_ff == 2'd0) begin
         if (!beat_byte_ff[7]) begin
            char_done = 1'b1;
            char_code = {8'd0, beat_byte_ff};
         end
      end else if (cont_ff == 2'd1) begin
         char_done = 1'b1;
         char_code = partial_ff | {10'd0, beat_byte_ff[5:0]};
      end

      chars_next = chars_ff + 31'd1;
      kept       = chars_ff < {15'd0, keep};
      str_end    = chars_next >= declared_ff;
      end_len    = (declared_ff < {15'd0, keep}) ? declared_ff[CODE_W-1:0] : keep;
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      vcount_in   = vcount_ff;
      declared_in = declared_ff;
      chars_in    = chars_ff;
      cont_in     = cont_ff;
      partial_in  = partial_ff;
      if (beat_valid_ff) begin
         case (phase_ff)
            PHASE_LEN: begin
               if (len_err) begin
                  vcount_in   = '0;
                  declared_in = '0;
                  chars_in    = '0;
                  cont_in     = '0;
                  partial_in  = '0;
               end else if (len_more) begin
                  declared_in = len_new;
                  vcount_in   = vcount_ff + 3'd1;
               end else begin
                  vcount_in  = '0;
                  chars_in   = '0;
                  cont_in    = '0;
                  partial_in = '0;
                  declared_in = len_new;
                  if (len_new != '0) begin
                     phase_in = PHASE_CHARS;
                  end
               end
            end
            PHASE_CHARS: begin
               if (cont_ff == 2'd0) begin
                  if (beat_byte_ff[7]) begin
                     if (beat_byte_ff[7:5] != 3'b111) begin
                        partial_in = {5'd0, beat_byte_ff[4:0], 6'd0};
                        cont_in    = 2'd1;
                     end else begin
                        partial_in = {beat_byte_ff[3:0], 12'd0};
                        cont_in    = 2'd2;
                     end
                  end
               end else if (cont_ff == 2'd1) begin
                  partial_in = '0;
                  cont_in    = 2'd0;
               end else begin
                  partial_in = partial_ff | {4'd0, beat_byte_ff[5:0], 6'd0};
                  cont_in    = 2'd1;
               end
               if (char_done) begin
                  if (str_end) begin
                     phase_in    = PHASE_LEN;
                     declared_in = '0;
                     chars_in    = '0;
                  end else begin
                     chars_in = chars_next;
                  end
               end
            end
            default: begin
               phase_in = PHASE_LEN;
            end
         endcase
      end
   end

   // result items
   always_comb begin
      push = '0;
      if (beat_valid_ff) begin
         case (phase_ff)
            PHASE_LEN: begin
               if (len_err) begin
                  push.count      = 2'd1;
                  push.first.kind = KIND_ERR;
                  push.first.last = 1'b1;
               end else if (!len_more && (len_new == '0)) begin
                  push.count      = 2'd1;
                  push.first.kind = KIND_END;
                  push.first.last = 1'b1;
               end
            end
            PHASE_CHARS: begin
               if (char_done) begin
                  if (kept) begin
                     push.first.kind  = KIND_CHAR;
                     push.first.code  = char_code;
                     push.first.index = chars_ff[CODE_W-1:0];
                     if (str_end) begin
                        push.count         = 2'd2;
                        push.second.kind   = KIND_END;
                        push.second.length = end_len;
                        push.second.last   = 1'b1;
                     end else begin
                        push.count = 2'd1;
                     end
                  end else if (str_end) begin
                     push.count        = 2'd1;
                     push.first.kind   = KIND_END;
                     push.first.length = end_len;
                     push.first.last   = 1'b1;
                  end
               end
            end
            default: begin
               push.count = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_LEN;
         vcount_ff   <= '0;
         declared_ff <= '0;
         chars_ff    <= '0;
         cont_ff     <= '0;
         partial_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         vcount_ff   <= vcount_in;
         declared_ff <= declared_in;
         chars_ff    <= chars_in;
         cont_ff     <= cont_in;
         partial_ff  <= partial_in;
      end
   end

endmodule

### sv/lpsd_queue.sv
// lpsd_queue: small result queue taking up to two items per cycle, one out per beat
// depends on lpsd_pkg; its head is the result channel's output register

module lpsd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  lpsd_pkg::push_type   push,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lpsd_pkg::item_type   out_item,
   output logic                 has_room
);
   import lpsd_pkg::*;

   item_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in;
   logic [QUEUE_AW-1:0]   rd_ff, rd_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  pop;
   logic [QUEUE_AW-1:0]   wr_second;

   assign out_valid = count_ff != '0;
   assign out_item  = entries_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign has_room  = (QUEUE_CW'(QUEUE_DEPTH) - count_ff) >= QUEUE_CW'(ROOM_NEEDED);
   assign wr_second = wr_ff + QUEUE_AW'(1);
   assign wr_in     = wr_ff + QUEUE_AW'(push.count);
   assign rd_in     = pop ? rd_ff + QUEUE_AW'(1) : rd_ff;
   assign count_in  = count_ff + QUEUE_CW'(push.count) - QUEUE_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_second] <= push.second;
      end
   end

endmodule

### sv/length_prefixed_utf8_string_decoder_core.sv
// length_prefixed_utf8_string_decoder_core: top level, buffer size register and stream ports
// depends on lpsd_pkg, lpsd_decode and lpsd_queue
// a byte beat passes the beat register and an eight-entry result queue to the result port
// throughput: one beat per cycle if four queue entries are free, one result per ready cycle
// reset: synchronous, clears the string state and the queue, buffer size returns to 256

module length_prefixed_utf8_string_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // char_code, char_index, string_length
   output logic [1:0]  rsp_tuser,   // item_kind
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data     // buffer_size
);
   import lpsd_pkg::*;

   logic [BUF_SIZE_W-1:0] buffer_size_ff, buffer_size_in;
   push_type              push;
   item_type              head;
   logic                  has_room;

   assign csr_ready      = 1'b1;
   assign buffer_size_in = (csr_valid && csr_ready) ? csr_data : buffer_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= BUF_SIZE_RESET;
      end else begin
         buffer_size_ff <= buffer_size_in;
      end
   end

   assign req_tready = has_room;

   lpsd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid && req_tready),
      .in_byte     (req_tdata),
      .buffer_size (buffer_size_ff),
      .push        (push)
   );

   lpsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head),
      .has_room  (has_room)
   );

   assign rsp_tdata = {head.length, head.index, head.code};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
